FILE: rtl/core/soh_frame_deframer_sum16_defines.svh
// assertion helpers for the soh frame deframer
`ifndef SOH_FRAME_DEFRAMER_SUM16_DEFINES_SVH
`define SOH_FRAME_DEFRAMER_SUM16_DEFINES_SVH

// checked only out of reset
`define SFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/core/sfd_pkg.sv
package sfd_pkg;

    localparam logic [7:0] SOH_BYTE  = 8'h01;
    localparam logic [7:0] TEXT_BYTE = 8'h24;
    localparam logic [7:0] LINE_END  = 8'h0A;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_TEXT  = 3'd1,
        PH_ID    = 3'd2,
        PH_COMP  = 3'd3,
        PH_LEN   = 3'd4,
        PH_DATA  = 3'd5,
        PH_CK_LO = 3'd6,
        PH_CK_HI = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] msg_id;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       payload_valid;
        logic       frame_done;
        logic       frame_good;
        logic [7:0] frame_length;
    } sfd_result_t;

    // handshake between the input register and the rest of the pipe
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } sfd_in_t;

endpackage

FILE: rtl/core/soh_frame_deframer_sum16.sv
// Byte-stream deframer for frames of SOH, id, inverted id, length, payload and a
// 16-bit byte sum sent low byte first. Text lines opened by '$' are skipped to the
// newline while hunting. Each payload byte comes out as one item carrying its index
// (tuser[0] set); the second checksum byte ends the frame with one item that has
// tlast set and tuser[1] telling whether both checksum bytes matched. Throughput is
// one byte per clock while the sink keeps up: the parser state and the 16-bit sum
// are updated combinationally between the input register and the output register,
// so a byte is held in the input register and its result in the output register.
// Input ready drops only while the output register holds an item the sink is
// stalling. No memories, no start-up delay.
module soh_frame_deframer_sum16
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] msg_id, [15:8] payload_byte,
                                        // [23:16] payload_index, [31:24] frame_length
    output logic        m_axis_tlast,   // frame_done
    output logic [1:0]  m_axis_tuser    // [0] payload_valid, [1] frame_good
);

    sfd_in_t     in_item;
    sfd_result_t result;
    logic        result_valid;
    logic        out_busy;
    logic        advance;

    assign advance = in_item.valid && !out_busy;

    sfd_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .in_item       (in_item)
    );

    sfd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .rx_byte      (in_item.rx_byte),
        .result       (result),
        .result_valid (result_valid)
    );

    sfd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && result_valid),
        .result        (result),
        .busy          (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/core/sfd_in_stage.sv
module sfd_in_stage
    import sfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       advance,
    output sfd_in_t    in_item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= s_axis_tdata;
        end
    end

    assign in_item.valid   = valid_reg;
    assign in_item.rx_byte = byte_reg;

endmodule

FILE: rtl/core/sfd_parser.sv
module sfd_parser
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output sfd_result_t result,
    output logic        result_valid
);

`include "soh_frame_deframer_sum16_defines.svh"

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  held_id_reg;
    logic [7:0]  held_id_next;
    logic [7:0]  held_length_reg;
    logic [7:0]  held_length_next;
    logic [7:0]  bytes_seen_reg;
    logic [7:0]  bytes_seen_next;
    logic [15:0] running_sum_reg;
    logic [15:0] running_sum_next;
    logic [7:0]  first_check_reg;
    logic [7:0]  first_check_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_id_reg     <= '0;
            held_length_reg <= '0;
            bytes_seen_reg  <= '0;
            running_sum_reg <= '0;
            first_check_reg <= '0;
        end else begin
            held_id_reg     <= held_id_next;
            held_length_reg <= held_length_next;
            bytes_seen_reg  <= bytes_seen_next;
            running_sum_reg <= running_sum_next;
            first_check_reg <= first_check_next;
        end
    end

    always_comb begin
        phase_next           = phase_reg;
        held_id_next         = held_id_reg;
        held_length_next     = held_length_reg;
        bytes_seen_next      = bytes_seen_reg;
        running_sum_next     = running_sum_reg;
        first_check_next     = first_check_reg;
        result               = '0;
        result.msg_id        = held_id_reg;
        result.frame_length  = held_length_reg;
        result_valid         = 1'b0;
        if (step) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == TEXT_BYTE) begin
                        phase_next = PH_TEXT;
                    end else if (rx_byte == SOH_BYTE) begin
                        phase_next = PH_ID;
                    end
                end
                PH_TEXT: begin
                    if (rx_byte == LINE_END) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_ID: begin
                    if (rx_byte != SOH_BYTE) begin
                        held_id_next = rx_byte;
                        phase_next   = PH_COMP;
                    end
                end
                PH_COMP: begin
                    if (rx_byte == SOH_BYTE) begin
                        phase_next = PH_ID;
                    end else if (~held_id_reg != rx_byte) begin
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    held_length_next = rx_byte;
                    bytes_seen_next  = '0;
                    running_sum_next = '0;
                    phase_next       = (rx_byte == 8'd0) ? PH_CK_LO : PH_DATA;
                end
                PH_DATA: begin
                    result.payload_byte  = rx_byte;
                    result.payload_index = bytes_seen_reg;
                    result.payload_valid = 1'b1;
                    result_valid         = 1'b1;
                    running_sum_next     = running_sum_reg + {8'd0, rx_byte};
                    bytes_seen_next      = bytes_seen_reg + 8'd1;
                    if (bytes_seen_next == held_length_reg) begin
                        phase_next = PH_CK_LO;
                    end
                end
                PH_CK_LO: begin
                    first_check_next = rx_byte;
                    phase_next       = PH_CK_HI;
                end
                PH_CK_HI: begin
                    result.frame_done = 1'b1;
                    result.frame_good = (first_check_reg == running_sum_reg[7:0]) &&
                                        (rx_byte == running_sum_reg[15:8]);
                    result_valid      = 1'b1;
                    phase_next        = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // the payload count never reaches the announced length inside the data phase
    `SFD_ASSERT(a_seen_below_length,
        (phase_reg == PH_DATA) |-> (bytes_seen_reg < held_length_reg),
        "payload count reached length in data phase")

    // the length byte clears the running sum for the new frame
    `SFD_ASSERT(a_sum_cleared,
        (step && phase_reg == PH_LEN) |=> (running_sum_reg == 16'd0 && bytes_seen_reg == 8'd0),
        "sum not cleared after length byte")

    // the last payload byte hands over to the checksum
    `SFD_ASSERT(a_data_to_check,
        (step && phase_reg == PH_DATA && bytes_seen_reg + 8'd1 == held_length_reg)
            |=> (phase_reg == PH_CK_LO),
        "missed checksum after last payload byte")

endmodule

FILE: rtl/core/sfd_out_stage.sv
module sfd_out_stage
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  sfd_result_t result,
    output logic        busy,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] msg_id, [15:8] payload_byte,
                                        // [23:16] payload_index, [31:24] frame_length
    output logic        m_axis_tlast,   // frame_done
    output logic [1:0]  m_axis_tuser    // [0] payload_valid, [1] frame_good
);

`include "soh_frame_deframer_sum16_defines.svh"

    logic        valid_reg;
    logic        valid_next;
    sfd_result_t result_reg;

    // a waiting item blocks the parser only while the sink stalls
    assign busy = valid_reg && !m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {result_reg.frame_length, result_reg.payload_index,
                            result_reg.payload_byte, result_reg.msg_id};
    assign m_axis_tlast  = result_reg.frame_done;
    assign m_axis_tuser  = {result_reg.frame_good, result_reg.payload_valid};

    // an item is either a payload byte or a frame end, never both
    `SFD_ASSERT(a_kind_exclusive,
        valid_reg |-> (result_reg.payload_valid != result_reg.frame_done),
        "output item kind is ambiguous")

    // nothing is loaded over an item that the sink has not taken
    `SFD_ASSERT_ALWAYS(a_no_overwrite,
        (aresetn && load) |-> (!valid_reg || m_axis_tready),
        "output item overwritten")

endmodule

FILE: verif/soh_frame_deframer_sum16_tb.sv
module soh_frame_deframer_sum16_tb;
    import sfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 100;
    localparam int RANDOM_BYTES   = 100;
    localparam int RANDOM_FILL    = -1;

    typedef enum int {
        CK_OK,
        CK_BAD_LO,
        CK_BAD_HI,
        CK_BAD_BOTH
    } ck_fault_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] msg_id, [15:8] payload_byte,
                                         // [23:16] payload_index, [31:24] frame_length
    logic        m_axis_tlast;           // frame_done
    logic [1:0]  m_axis_tuser;           // [0] payload_valid, [1] frame_good

    // deframer state as the stream should leave it
    phase_t      parse_phase = PH_HUNT;
    logic [7:0]  cur_id = 8'h00;
    logic [7:0]  cur_len = 8'h00;
    logic [7:0]  payload_count = 8'h00;
    logic [15:0] payload_sum = 16'h0000;
    logic [7:0]  sum_lo_byte = 8'h00;

    sfd_result_t frame_results_q[$];

    int error_count = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    soh_frame_deframer_sum16 DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic int gap_length();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_error(input string msg);
        // keep the log short when the block is badly off
        if (error_count < MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_seen, name, got, want));
        end
    endtask

    // advance the deframer state by one byte and queue the result it gives
    task automatic track_byte(input logic [7:0] b);
        sfd_result_t r;
        case (parse_phase)
            PH_HUNT: begin
                if (b == TEXT_BYTE) parse_phase = PH_TEXT;
                else if (b == SOH_BYTE) parse_phase = PH_ID;
            end
            PH_TEXT: begin
                if (b == LINE_END) parse_phase = PH_HUNT;
            end
            PH_ID: begin
                if (b != SOH_BYTE) begin
                    cur_id = b;
                    parse_phase = PH_COMP;
                end
            end
            PH_COMP: begin
                if (b == SOH_BYTE) parse_phase = PH_ID;
                else if (~cur_id != b) parse_phase = PH_HUNT;
                else parse_phase = PH_LEN;
            end
            PH_LEN: begin
                cur_len = b;
                payload_count = 8'h00;
                payload_sum = 16'h0000;
                parse_phase = (b == 8'h00) ? PH_CK_LO : PH_DATA;
            end
            PH_DATA: begin
                r = '{msg_id: cur_id, payload_byte: b, payload_index: payload_count,
                      payload_valid: 1'b1, frame_done: 1'b0, frame_good: 1'b0,
                      frame_length: cur_len};
                frame_results_q.push_back(r);
                payload_sum = payload_sum + 16'(b);
                payload_count = payload_count + 8'd1;
                if (payload_count == cur_len) parse_phase = PH_CK_LO;
            end
            PH_CK_LO: begin
                sum_lo_byte = b;
                parse_phase = PH_CK_HI;
            end
            default: begin
                r = '{msg_id: cur_id, payload_byte: 8'h00, payload_index: 8'h00,
                      payload_valid: 1'b0, frame_done: 1'b1,
                      frame_good: (sum_lo_byte == payload_sum[7:0]) &&
                                  (b == payload_sum[15:8]),
                      frame_length: cur_len};
                frame_results_q.push_back(r);
                parse_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] id, input int len, input int fill,
                              input ck_fault_t fault);
        logic [15:0] sum;
        logic [7:0]  b;
        logic [7:0]  lo;
        logic [7:0]  hi;
        sum = 16'h0000;
        send_byte(SOH_BYTE);
        send_byte(id);
        send_byte(~id);
        send_byte(8'(len));
        for (int i = 0; i < len; i++) begin
            b = (fill == RANDOM_FILL) ? 8'($urandom_range(0, 255)) : 8'(fill);
            send_byte(b);
            sum = sum + 16'(b);
        end
        lo = sum[7:0];
        hi = sum[15:8];
        if (fault == CK_BAD_LO || fault == CK_BAD_BOTH) lo = lo ^ 8'($urandom_range(1, 255));
        if (fault == CK_BAD_HI || fault == CK_BAD_BOTH) hi = hi ^ 8'($urandom_range(1, 255));
        send_byte(lo);
        send_byte(hi);
    endtask

    // feed bytes that bring the parser back to hunting
    task automatic return_to_hunt();
        while (parse_phase != PH_HUNT) begin
            case (parse_phase)
                PH_TEXT: send_byte(LINE_END);
                PH_ID:   send_byte(8'h02);
                PH_COMP: send_byte(cur_id);    // never equal to its complement
                PH_LEN:  send_byte(8'h00);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic test_text_line();
        logic [7:0] seq[$];
        // a whole header inside a text line must be ignored
        seq = {TEXT_BYTE, SOH_BYTE, 8'h37, 8'hC8, 8'h03, LINE_END};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_header_restarts();
        logic [7:0] seq[$];
        // soh as id, then soh as complement, then an empty frame with id 00
        seq = {SOH_BYTE, SOH_BYTE, 8'hFF, SOH_BYTE, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_complement_mismatch();
        logic [7:0] seq[$];
        // the mismatching '$' must not open a text line
        seq = {SOH_BYTE, 8'h5A, TEXT_BYTE};
        foreach (seq[i]) send_byte(seq[i]);
        send_frame(8'hFF, 1, 8'hFF, CK_OK);
    endtask

    task automatic test_bad_checksum();
        send_frame(8'hA5, 1, 8'h80, CK_BAD_HI);
        send_frame(8'h5A, 2, 8'h7F, CK_BAD_LO);
    endtask

    task automatic test_long_frame();
        return_to_hunt();
        send_frame(8'($urandom_range(2, 255)), 255, RANDOM_FILL, CK_OK);
    endtask

    task automatic test_random_traffic();
        int start;
        int next_switch;
        int r;
        int n;
        int len;
        ck_fault_t fault;
        start = bytes_sent;
        next_switch = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (bytes_sent >= next_switch) begin
                quiet = ($urandom_range(0, 3) == 0);
                next_switch = bytes_sent + 40;
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                if ($urandom_range(0, 9) != 0) return_to_hunt();
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, 40);
                fault = ($urandom_range(0, 4) == 0) ? ck_fault_t'($urandom_range(1, 3))
                                                    : CK_OK;
                send_frame(8'($urandom_range(0, 255)), len, RANDOM_FILL, fault);
            end else if (r < 75) begin
                send_byte(TEXT_BYTE);
                n = $urandom_range(0, 6);
                repeat (n) send_byte(8'($urandom_range(11, 255)));
                send_byte(LINE_END);
            end else if (r < 85) begin
                n = $urandom_range(0, 255);
                send_byte(SOH_BYTE);
                send_byte(8'(n));
                send_byte(8'(~n) ^ 8'($urandom_range(1, 255)));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls and the check of each item
    always @(posedge aclk) begin
        if (stall_left == 0) stall_left = gap_length();
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sfd_result_t got;
        sfd_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.msg_id        = m_axis_tdata[7:0];
            got.payload_byte  = m_axis_tdata[15:8];
            got.payload_index = m_axis_tdata[23:16];
            got.frame_length  = m_axis_tdata[31:24];
            got.payload_valid = m_axis_tuser[0];
            got.frame_good    = m_axis_tuser[1];
            got.frame_done    = m_axis_tlast;
            if (frame_results_q.size() == 0) begin
                report_error($sformatf("unexpected item, tdata %h tuser %b tlast %b",
                                       m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                want = frame_results_q.pop_front();
                check_field("msg_id", got.msg_id, want.msg_id);
                check_field("payload_byte", got.payload_byte, want.payload_byte);
                check_field("payload_index", got.payload_index, want.payload_index);
                check_field("payload_valid", got.payload_valid, want.payload_valid);
                check_field("frame_done", got.frame_done, want.frame_done);
                check_field("frame_good", got.frame_good, want.frame_good);
                check_field("frame_length", got.frame_length, want.frame_length);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("soh_frame_deframer_sum16_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_text_line();
        test_header_restarts();
        test_complement_mismatch();
        test_bad_checksum();
        test_long_frame();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0) begin
            $display("soh_frame_deframer_sum16_tb passed");
        end else begin
            $display("soh_frame_deframer_sum16_tb failed");
        end
        $finish;
    end

endmodule

FILE: soh_frame_deframer_sum16.f
+incdir+rtl/core
rtl/core/sfd_pkg.sv
rtl/core/sfd_in_stage.sv
rtl/core/sfd_parser.sv
rtl/core/sfd_out_stage.sv
rtl/core/soh_frame_deframer_sum16.sv
verif/soh_frame_deframer_sum16_tb.sv
